[hw/rtl/gfv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfv_pkg
// Shared constants for the 2D pairwise gravity force block.
// ----------------------------------------------------------------------------
package gfv_pkg;

    localparam int GFV_COORD_BITS  = 16;
    localparam int GFV_MASS_BITS   = 16;
    localparam int GFV_FRAC_BITS   = 16;
    localparam int GFV_ROOT_FRAC   = 16;
    localparam int GFV_OUT_BITS    = 48;
    localparam int GFV_GAIN_BITS   = 16;
    localparam int GFV_GAIN_FRAC   = 8;
    localparam int GFV_QUEUE_DEPTH = 2;

    localparam logic [GFV_GAIN_BITS-1:0] GFV_GAIN_RESET = 16'd256;

endpackage

[hw/rtl/gfv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfv_if
// Valid/ready channels for body pairs in and force results out.
// ----------------------------------------------------------------------------
interface gfv_in_if #(
    parameter int COORD_BITS = 16,
    parameter int MASS_BITS  = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic        [MASS_BITS-1:0]  first_mass;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic        [MASS_BITS-1:0]  second_mass;

    modport source (output valid, first_x, first_y, first_mass,
                    second_x, second_y, second_mass, input ready);
    modport sink   (input valid, first_x, first_y, first_mass,
                    second_x, second_y, second_mass, output ready);
endinterface

interface gfv_out_if #(
    parameter int OUT_BITS = 48
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] force_x;
    logic signed [OUT_BITS-1:0] force_y;
    logic                       coincident;
    logic                       saturated;

    modport source (output valid, force_x, force_y, coincident, saturated,
                    input ready);
    modport sink   (input valid, force_x, force_y, coincident, saturated,
                    output ready);
endinterface

[hw/rtl/gfv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfv_front
// Takes a body pair, forms the separation and flags coincident bodies.
// ----------------------------------------------------------------------------
module gfv_front #(
    parameter int COORD_BITS = 16,
    parameter int MASS_BITS  = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    gfv_in_if.sink                                        i_in,
    output logic                                          o_item_valid,
    output logic [1+2*(COORD_BITS+1)+2*MASS_BITS-1:0]     o_item_data,
    input  logic                                          i_item_ready
);
    localparam int DW = COORD_BITS + 1;

    logic                 r_valid;
    logic                 r_coinc;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic [MASS_BITS-1:0] r_m1;
    logic [MASS_BITS-1:0] r_m2;

    logic                 load;
    logic signed [DW-1:0] n_dx;
    logic signed [DW-1:0] n_dy;

    assign load       = !r_valid || i_item_ready;
    assign i_in.ready = load;

    assign n_dx = DW'(i_in.second_x) - DW'(i_in.first_x);
    assign n_dy = DW'(i_in.second_y) - DW'(i_in.first_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_coinc <= (n_dx == '0) && (n_dy == '0);
            r_m1    <= i_in.first_mass;
            r_m2    <= i_in.second_mass;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item_data  = {r_coinc, r_dx, r_dy, r_m1, r_m2};
endmodule

[hw/rtl/gfv_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfv_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module gfv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = r_cnt != (PW+1)'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end
endmodule

[hw/rtl/gfv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfv_back
// Force pipeline: squares, square root, denominator, two long dividers.
// ----------------------------------------------------------------------------
module gfv_back #(
    parameter int COORD_BITS = 16,
    parameter int MASS_BITS  = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [gfv_pkg::GFV_GAIN_BITS-1:0]         i_grav_gain,
    input  logic                                      i_item_valid,
    input  logic [1+2*(COORD_BITS+1)+2*MASS_BITS-1:0] i_item_data,
    output logic                                      o_item_ready,
    gfv_out_if.source                                 o_out
);
    import gfv_pkg::*;

    localparam int DW     = COORD_BITS + 1;
    localparam int IW     = 1 + 2 * DW + 2 * MASS_BITS;
    localparam int ABS_W  = COORD_BITS;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int R2_W   = SQ_W + 1;
    localparam int ROOT_W = COORD_BITS + 1 + GFV_ROOT_FRAC;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int GM1_W  = GFV_GAIN_BITS + MASS_BITS;
    localparam int BASE_W = GM1_W + MASS_BITS;
    localparam int NC_W   = BASE_W + ABS_W;
    localparam int SH     = FRAC_BITS - GFV_GAIN_FRAC + GFV_ROOT_FRAC;
    localparam int NUM_W  = NC_W + SH;
    localparam int OUT    = GFV_OUT_BITS;
    localparam int HI_W   = NUM_W - OUT;
    localparam int RL     = ROOT_W / 2;
    localparam int RH     = ROOT_W - RL;
    localparam int DEN_W  = R2_W + ROOT_W;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CRY_W  = R2_W + BASE_W + 2 * ABS_W + 3;

    logic en;
    logic r_out_valid;

    assign en           = !r_out_valid || o_out.ready;
    assign o_item_ready = en;

    // unpack the queued item
    logic                 it_c;
    logic signed [DW-1:0] it_dx;
    logic signed [DW-1:0] it_dy;
    logic [MASS_BITS-1:0] it_m1;
    logic [MASS_BITS-1:0] it_m2;
    logic [DW-1:0]        neg_dx;
    logic [DW-1:0]        neg_dy;

    assign it_c   = i_item_data[IW-1];
    assign it_dx  = i_item_data[IW-2 -: DW];
    assign it_dy  = i_item_data[IW-2-DW -: DW];
    assign it_m1  = i_item_data[2*MASS_BITS-1 -: MASS_BITS];
    assign it_m2  = i_item_data[MASS_BITS-1:0];
    assign neg_dx = -it_dx;
    assign neg_dy = -it_dy;

    // stage 1: magnitudes
    logic                 r_s1_valid;
    logic [ABS_W-1:0]     r_s1_ax, r_s1_ay;
    logic [2:0]           r_s1_flg;
    logic [MASS_BITS-1:0] r_s1_m1, r_s1_m2;

    // stage 2: squares, gain * m1
    logic                 r_s2_valid;
    logic [SQ_W-1:0]      r_s2_ax2, r_s2_ay2;
    logic [GM1_W-1:0]     r_s2_gm1;
    logic [ABS_W-1:0]     r_s2_ax, r_s2_ay;
    logic [2:0]           r_s2_flg;
    logic [MASS_BITS-1:0] r_s2_m2;

    // stage 3: r2 and the mass product
    logic                 r_s3_valid;
    logic [R2_W-1:0]      r_s3_r2;
    logic [BASE_W-1:0]    r_s3_base;
    logic [ABS_W-1:0]     r_s3_ax, r_s3_ay;
    logic [2:0]           r_s3_flg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_item_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ax   <= it_dx[DW-1] ? neg_dx[ABS_W-1:0] : it_dx[ABS_W-1:0];
            r_s1_ay   <= it_dy[DW-1] ? neg_dy[ABS_W-1:0] : it_dy[ABS_W-1:0];
            r_s1_flg  <= {it_c, it_dy[DW-1], it_dx[DW-1]};
            r_s1_m1   <= it_m1;
            r_s1_m2   <= it_m2;

            r_s2_ax2  <= r_s1_ax * r_s1_ax;
            r_s2_ay2  <= r_s1_ay * r_s1_ay;
            r_s2_gm1  <= i_grav_gain * r_s1_m1;
            r_s2_ax   <= r_s1_ax;
            r_s2_ay   <= r_s1_ay;
            r_s2_flg  <= r_s1_flg;
            r_s2_m2   <= r_s1_m2;

            r_s3_r2   <= R2_W'(r_s2_ax2) + R2_W'(r_s2_ay2);
            r_s3_base <= r_s2_gm1 * r_s2_m2;
            r_s3_ax   <= r_s2_ax;
            r_s3_ay   <= r_s2_ay;
            r_s3_flg  <= r_s2_flg;
        end
    end

    // square root of r2 * 2^(2*ROOT_FRAC), one result bit per stage
    logic              r_sq_valid [ROOT_W];
    logic [RAD_W-1:0]  r_sq_rad   [ROOT_W];
    logic [ROOT_W+1:0] r_sq_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root  [ROOT_W];
    logic [CRY_W-1:0]  r_sq_cry   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic              in_v;
        logic [RAD_W-1:0]  in_rad;
        logic [ROOT_W+1:0] in_rem;
        logic [ROOT_W-1:0] in_root;
        logic [CRY_W-1:0]  in_cry;
        logic [ROOT_W+1:0] rem_s;
        logic [ROOT_W+1:0] trial;

        if (k == 0) begin : g_first
            assign in_v    = r_s3_valid;
            assign in_rad  = RAD_W'({r_s3_r2, {(2*GFV_ROOT_FRAC){1'b0}}});
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_cry  = {r_s3_r2, r_s3_base, r_s3_ax, r_s3_ay, r_s3_flg};
        end else begin : g_next
            assign in_v    = r_sq_valid[k-1];
            assign in_rad  = r_sq_rad[k-1];
            assign in_rem  = r_sq_rem[k-1];
            assign in_root = r_sq_root[k-1];
            assign in_cry  = r_sq_cry[k-1];
        end

        assign rem_s = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
        assign trial = {in_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else if (en) begin
                r_sq_valid[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rad[k] <= in_rad << 2;
                r_sq_cry[k] <= in_cry;
                if (rem_s >= trial) begin
                    r_sq_rem[k]  <= rem_s - trial;
                    r_sq_root[k] <= {in_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_sq_rem[k]  <= rem_s;
                    r_sq_root[k] <= {in_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    logic [ROOT_W-1:0] sq_root;
    logic [R2_W-1:0]   sq_r2;
    logic [BASE_W-1:0] sq_base;
    logic [ABS_W-1:0]  sq_ax, sq_ay;
    logic [2:0]        sq_flg;

    assign sq_root = r_sq_root[ROOT_W-1];
    assign {sq_r2, sq_base, sq_ax, sq_ay, sq_flg} = r_sq_cry[ROOT_W-1];

    // denominator r2 * root in two halves, numerators base * |d|
    logic               r_d1_valid, r_d2_valid, r_d3_valid;
    logic [R2_W+RL-1:0] r_d1_plo;
    logic [R2_W+RH-1:0] r_d1_phi;
    logic [NC_W-1:0]    r_d1_num [2];
    logic [2:0]         r_d1_flg;
    logic [DEN_W-1:0]   r_d2_den;
    logic [NC_W-1:0]    r_d2_num [2];
    logic [2:0]         r_d2_flg;
    logic [DEN_W-1:0]   r_d3_den;
    logic [DEN_W-1:0]   r_d3_rem [2];
    logic [OUT-1:0]     r_d3_lo  [2];
    logic               r_d3_ov  [2];
    logic [2:0]         r_d3_flg;

    logic [NUM_W-1:0]   d2_num  [2];
    logic [CMP_W-1:0]   d2_hi   [2];
    logic [CMP_W-1:0]   d2_den;

    always_comb begin
        d2_den = CMP_W'(r_d2_den);
        for (int i = 0; i < 2; i++) begin
            d2_num[i] = {r_d2_num[i], {SH{1'b0}}};
            d2_hi[i]  = CMP_W'(d2_num[i][NUM_W-1:OUT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
            r_d3_valid <= 1'b0;
        end else if (en) begin
            r_d1_valid <= r_sq_valid[ROOT_W-1];
            r_d2_valid <= r_d1_valid;
            r_d3_valid <= r_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_plo    <= sq_r2 * sq_root[RL-1:0];
            r_d1_phi    <= sq_r2 * sq_root[ROOT_W-1:RL];
            r_d1_num[0] <= sq_base * sq_ax;
            r_d1_num[1] <= sq_base * sq_ay;
            r_d1_flg    <= sq_flg;

            r_d2_den    <= DEN_W'(r_d1_plo) + (DEN_W'(r_d1_phi) << RL);
            r_d2_num    <= r_d1_num;
            r_d2_flg    <= r_d1_flg;

            r_d3_den    <= r_d2_den;
            r_d3_flg    <= r_d2_flg;
            for (int i = 0; i < 2; i++) begin
                // quotient of 2^OUT or more always clips
                r_d3_ov[i]  <= d2_hi[i] >= d2_den;
                r_d3_rem[i] <= d2_hi[i][DEN_W-1:0];
                r_d3_lo[i]  <= d2_num[i][OUT-1:0];
            end
        end
    end

    // restoring division, one quotient bit per stage for each component
    logic             r_dv_valid [OUT];
    logic [DEN_W-1:0] r_dv_den   [OUT];
    logic [2:0]       r_dv_flg   [OUT];
    logic [DEN_W-1:0] r_dv_rem   [OUT][2];
    logic [OUT-1:0]   r_dv_lo    [OUT][2];
    logic [OUT-1:0]   r_dv_q     [OUT][2];
    logic             r_dv_ov    [OUT][2];

    for (genvar j = 0; j < OUT; j++) begin : g_div
        logic             in_v;
        logic [DEN_W-1:0] in_den;
        logic [2:0]       in_flg;
        logic [DEN_W-1:0] in_rem [2];
        logic [OUT-1:0]   in_lo  [2];
        logic [OUT-1:0]   in_q   [2];
        logic             in_ov  [2];
        logic [DEN_W:0]   trial  [2];
        logic [DEN_W:0]   diff   [2];
        logic             take   [2];

        if (j == 0) begin : g_first
            assign in_v   = r_d3_valid;
            assign in_den = r_d3_den;
            assign in_flg = r_d3_flg;
            always_comb begin
                for (int i = 0; i < 2; i++) begin
                    in_rem[i] = r_d3_rem[i];
                    in_lo[i]  = r_d3_lo[i];
                    in_q[i]   = '0;
                    in_ov[i]  = r_d3_ov[i];
                end
            end
        end else begin : g_next
            assign in_v   = r_dv_valid[j-1];
            assign in_den = r_dv_den[j-1];
            assign in_flg = r_dv_flg[j-1];
            always_comb begin
                for (int i = 0; i < 2; i++) begin
                    in_rem[i] = r_dv_rem[j-1][i];
                    in_lo[i]  = r_dv_lo[j-1][i];
                    in_q[i]   = r_dv_q[j-1][i];
                    in_ov[i]  = r_dv_ov[j-1][i];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 2; i++) begin
                trial[i] = {in_rem[i], in_lo[i][OUT-1]};
                take[i]  = trial[i] >= {1'b0, in_den};
                diff[i]  = trial[i] - {1'b0, in_den};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j] <= 1'b0;
            end else if (en) begin
                r_dv_valid[j] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_den[j] <= in_den;
                r_dv_flg[j] <= in_flg;
                for (int i = 0; i < 2; i++) begin
                    r_dv_rem[j][i] <= take[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
                    r_dv_lo[j][i]  <= in_lo[i] << 1;
                    r_dv_q[j][i]   <= {in_q[i][OUT-2:0], take[i]};
                    r_dv_ov[j][i]  <= in_ov[i];
                end
            end
        end
    end

    // clip, apply sign, register the result
    logic [2:0]     fin_flg;
    logic [OUT-1:0] lim  [2];
    logic           clip [2];
    logic [OUT-1:0] mag  [2];
    logic [OUT-1:0] val  [2];

    assign fin_flg = r_dv_flg[OUT-1];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            lim[i]  = fin_flg[i] ? {1'b1, {(OUT-1){1'b0}}} : {1'b0, {(OUT-1){1'b1}}};
            clip[i] = r_dv_ov[OUT-1][i] || (r_dv_q[OUT-1][i] > lim[i]);
            mag[i]  = clip[i] ? lim[i] : r_dv_q[OUT-1][i];
            val[i]  = fin_flg[i] ? -mag[i] : mag[i];
        end
    end

    logic signed [OUT-1:0] r_fx, r_fy;
    logic                  r_coinc, r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_valid[OUT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // coincident bodies: drop the meaningless quotient
            r_coinc <= fin_flg[2];
            r_sat   <= !fin_flg[2] && (clip[0] || clip[1]);
            r_fx    <= fin_flg[2] ? '0 : val[0];
            r_fy    <= fin_flg[2] ? '0 : val[1];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.force_x    = r_fx;
    assign o_out.force_y    = r_fy;
    assign o_out.coincident = r_coinc;
    assign o_out.saturated  = r_sat;
endmodule

[hw/rtl/gravity_force_vector_2d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_force_vector_2d_top
// Pairwise 2D gravitational force, both components per body pair.
// ----------------------------------------------------------------------------
// Takes one body pair per clock while the output is taken and returns
// gain*m1*m2*d/|d|^3 for x and y, signed with FRAC_BITS fraction bits,
// clipped to 48 bits with a saturated flag; coincident bodies give zero
// force and the coincident flag. The path runs through one front register,
// the queue, three product stages, one stage per root bit of the square root
// (COORD_BITS + 17), three denominator/numerator stages, one stage per
// quotient bit of the dividers (48) and the output register. The result
// register stalls the whole back pipeline while the output is not taken;
// the front keeps accepting until the queue and the front register are full.
// grav_gain resets to 1.0 and should be written only while no item is in
// flight.
module gravity_force_vector_2d_top #(
    parameter int COORD_BITS = gfv_pkg::GFV_COORD_BITS,
    parameter int MASS_BITS  = gfv_pkg::GFV_MASS_BITS,
    parameter int FRAC_BITS  = gfv_pkg::GFV_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gfv_pkg::GFV_GAIN_BITS-1:0] i_cfg_wdata,
    gfv_in_if.sink                            i_in,
    gfv_out_if.source                         o_out
);
    import gfv_pkg::*;

    localparam int IW = 1 + 2 * (COORD_BITS + 1) + 2 * MASS_BITS;

    logic [GFV_GAIN_BITS-1:0] r_grav_gain;
    logic                     f_valid, f_ready;
    logic [IW-1:0]            f_data;
    logic                     q_valid, q_ready;
    logic [IW-1:0]            q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_gain <= GFV_GAIN_RESET;
        end else if (i_cfg_we) begin
            r_grav_gain <= i_cfg_wdata;
        end
    end

    gfv_front #(
        .COORD_BITS (COORD_BITS),
        .MASS_BITS  (MASS_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (f_valid),
        .o_item_data  (f_data),
        .i_item_ready (f_ready)
    );

    gfv_queue #(
        .WIDTH (IW),
        .DEPTH (GFV_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  (f_data),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data),
        .i_pop_ready  (q_ready)
    );

    gfv_back #(
        .COORD_BITS (COORD_BITS),
        .MASS_BITS  (MASS_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grav_gain  (r_grav_gain),
        .i_item_valid (q_valid),
        .i_item_data  (q_data),
        .o_item_ready (q_ready),
        .o_out        (o_out)
    );
endmodule

[hw/rtl/gfv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfv_checker
// Port-level checks on the force result channel.
// ----------------------------------------------------------------------------
module gfv_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_out_valid,
    input logic                                    i_out_ready,
    input logic signed [gfv_pkg::GFV_OUT_BITS-1:0] i_force_x,
    input logic signed [gfv_pkg::GFV_OUT_BITS-1:0] i_force_y,
    input logic                                    i_coincident,
    input logic                                    i_saturated
);
    import gfv_pkg::*;

    localparam logic [GFV_OUT_BITS-1:0] FMAX = {1'b0, {(GFV_OUT_BITS-1){1'b1}}};
    localparam logic [GFV_OUT_BITS-1:0] FMIN = {1'b1, {(GFV_OUT_BITS-1){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_coincident |->
            i_force_x == '0 && i_force_y == '0 && !i_saturated)
        else $error("coincident result carries force or saturation");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |->
            i_force_x == FMAX || i_force_x == FMIN ||
            i_force_y == FMAX || i_force_y == FMIN)
        else $error("saturated without a clipped component");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind gravity_force_vector_2d_top gfv_checker u_gfv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_force_x    (o_out.force_x),
    .i_force_y    (o_out.force_y),
    .i_coincident (o_out.coincident),
    .i_saturated  (o_out.saturated)
);

[tb/sv/tb_gravity_force_vector_2d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gravity_force_vector_2d_top
// Streams body pairs through the gravity force block under several gains,
// with bursty input and a stalling receiver. Every result is checked against
// an exact integer prediction of both force components and both flags.
// ----------------------------------------------------------------------------
module tb_gravity_force_vector_2d_top;
    import gfv_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [15:0]        am;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [15:0]        bm;
    } body_pair_t;

    typedef struct packed {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic               coincident;
        logic               saturated;
    } force_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [GFV_GAIN_BITS-1:0] i_cfg_wdata = '0;

    gfv_in_if #(.COORD_BITS(16), .MASS_BITS(16)) in_ch();
    gfv_out_if #(.OUT_BITS(48)) out_ch();

    gravity_force_vector_2d_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch), .o_out(out_ch)
    );

    always #5 i_clk = ~i_clk;

    body_pair_t pending_pairs[$];
    force_t     expected_forces[$];
    logic [15:0] gain_copy = GFV_GAIN_RESET;
    int errors = 0;
    int n_results = 0, n_sat = 0, n_coin = 0;
    int cycles = 0;
    bit pair_taken = 0;
    int burst_left = 0, gap_left = 0;
    int stall_mode = 0, mode_left = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.first_x = '0; in_ch.first_y = '0; in_ch.first_mass = '0;
        in_ch.second_x = '0; in_ch.second_y = '0; in_ch.second_mass = '0;
        out_ch.ready = 1'b0;
    end

    // One component: floor(base*|d|/den), clipped, then signed by d.
    function automatic logic [47:0] force_component(logic signed [17:0] d,
            logic [127:0] base, logic [127:0] den, ref bit sat);
        logic [127:0] mag, q, cap, lim;
        mag = d < 0 ? 128'(-d) : 128'(d);
        cap = 128'(1) << 47;
        lim = d < 0 ? cap : cap - 1;
        q = (base * mag) / den;
        if (q > lim) begin
            q = lim;
            sat = 1;
        end
        if (d < 0) q = -q;
        return q[47:0];
    endfunction

    function automatic force_t predict_force(body_pair_t p, logic [15:0] g);
        logic signed [17:0] dx, dy;
        logic [127:0] ax, ay, r2, target, root, c, den, base;
        force_t f;
        bit sat;
        f = '0;
        sat = 0;
        dx = 18'(p.bx) - 18'(p.ax);
        dy = 18'(p.by) - 18'(p.ay);
        ax = dx < 0 ? 128'(-dx) : 128'(dx);
        ay = dy < 0 ? 128'(-dy) : 128'(dy);
        r2 = ax * ax + ay * ay;
        if (r2 == 0) begin
            f.coincident = 1;
            return f;
        end
        target = r2 << 32;
        root = 0;
        for (int b = 62; b >= 0; b--) begin
            c = root | (128'(1) << b);
            if (c * c <= target) root = c;
        end
        den = r2 * root;
        base = ((128'(g) * 128'(p.am) * 128'(p.bm)) << 24);
        f.fx = force_component(dx, base, den, sat);
        f.fy = force_component(dy, base, den, sat);
        f.saturated = sat;
        return f;
    endfunction

    function automatic body_pair_t random_pair();
        body_pair_t p;
        int kind;
        p = body_pair_t'({$urandom, $urandom, $urandom});
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // close bodies: large forces, frequent clipping
            p.bx = p.ax + 16'($urandom_range(0, 16)) - 16'sd8;
            p.by = p.ay + 16'($urandom_range(0, 16)) - 16'sd8;
        end else if (kind < 45) begin
            p.bx = p.ax;
            p.by = p.ay;
        end else if (kind < 55) begin
            p.ax = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            p.bx = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        end else if (kind < 60) begin
            p.am = 16'($urandom_range(0, 3));
        end
        return p;
    endfunction

    function automatic body_pair_t make_pair(int x1, int y1, int m1,
            int x2, int y2, int m2);
        body_pair_t p;
        p.ax = 16'(x1); p.ay = 16'(y1); p.am = 16'(m1);
        p.bx = 16'(x2); p.by = 16'(y2); p.bm = 16'(m2);
        return p;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Predict on each accepted input transfer.
    always @(posedge i_clk) begin
        pair_taken = in_ch.valid && in_ch.ready;
        if (pair_taken)
            expected_forces.push_back(predict_force({in_ch.first_x, in_ch.first_y,
                in_ch.first_mass, in_ch.second_x, in_ch.second_y,
                in_ch.second_mass}, gain_copy));
    end

    // Driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || pair_taken)) begin
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_pairs.size() > 0) begin
                body_pair_t p;
                p = pending_pairs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.first_x <= p.ax; in_ch.first_y <= p.ay;
                in_ch.first_mass <= p.am; in_ch.second_x <= p.bx;
                in_ch.second_y <= p.by; in_ch.second_mass <= p.bm;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: switch between always ready, random stalls and long stalls.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(10, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (expected_forces.size() == 0) begin
                errors++;
                $display("%t unexpected result fx=%0d fy=%0d", $realtime,
                    out_ch.force_x, out_ch.force_y);
            end else begin
                force_t e;
                e = expected_forces.pop_front();
                n_results++;
                if (e.saturated) n_sat++;
                if (e.coincident) n_coin++;
                if (out_ch.force_x !== e.fx) begin
                    errors++;
                    $display("%t force_x expected %0d actual %0d", $realtime,
                        e.fx, out_ch.force_x);
                end
                if (out_ch.force_y !== e.fy) begin
                    errors++;
                    $display("%t force_y expected %0d actual %0d", $realtime,
                        e.fy, out_ch.force_y);
                end
                if (out_ch.coincident !== e.coincident) begin
                    errors++;
                    $display("%t coincident expected %0b actual %0b", $realtime,
                        e.coincident, out_ch.coincident);
                end
                if (out_ch.saturated !== e.saturated) begin
                    errors++;
                    $display("%t saturated expected %0b actual %0b", $realtime,
                        e.saturated, out_ch.saturated);
                end
            end
        end
    end

    task automatic drain_pipeline();
        while (pending_pairs.size() > 0 || in_ch.valid || expected_forces.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [15:0] g);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = g;
        @(posedge i_clk);
        gain_copy = g;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [15:0] gains[7];
        gains = '{16'd256, 16'd65535, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
        for (int i = 4; i < 7; i++) gains[i] = 16'($urandom);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pairs at reset gain.
        pending_pairs.push_back(make_pair(5, -7, 100, 5, -7, 200));
        pending_pairs.push_back(make_pair(-32768, -32768, 65535, -32768, -32768, 65535));
        pending_pairs.push_back(make_pair(-32768, -32768, 65535, 32767, 32767, 65535));
        pending_pairs.push_back(make_pair(32767, 32767, 65535, -32768, -32768, 65535));
        pending_pairs.push_back(make_pair(0, 0, 65535, 1, 0, 65535));
        pending_pairs.push_back(make_pair(0, 0, 65535, 0, -1, 65535));
        pending_pairs.push_back(make_pair(0, 0, 65535, 1, 1, 65535));
        pending_pairs.push_back(make_pair(0, 0, 0, 3, 4, 65535));
        pending_pairs.push_back(make_pair(0, 0, 1000, 3, 4, 0));
        pending_pairs.push_back(make_pair(0, 0, 1, 3, 4, 1));
        pending_pairs.push_back(make_pair(10, 20, 1, 32767, -32768, 1));
        pending_pairs.push_back(make_pair(-32768, 0, 65535, 32767, 0, 65535));
        pending_pairs.push_back(make_pair(0, 32767, 300, 0, -32768, 400));
        pending_pairs.push_back(make_pair(100, 100, 65535, 99, 101, 65535));
        pending_pairs.push_back(make_pair(-1, -1, 255, -4, -5, 255));
        pending_pairs.push_back(make_pair(1, 2, 65535, 1, 2, 0));
        drain_pipeline();

        foreach (gains[i]) begin
            write_gain(gains[i]);
            repeat (150) pending_pairs.push_back(random_pair());
            drain_pipeline();
        end

        $display("checked %0d force results over %0d gain settings", n_results, 7);
        $display("%0d saturated, %0d coincident, %0d errors", n_sat, n_coin, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[gravity_force_vector_2d_top.f]
hw/rtl/gfv_pkg.sv
hw/rtl/gfv_if.sv
hw/rtl/gfv_front.sv
hw/rtl/gfv_queue.sv
hw/rtl/gfv_back.sv
hw/rtl/gravity_force_vector_2d_top.sv
hw/rtl/gfv_checker.sv
tb/sv/tb_gravity_force_vector_2d_top.sv
